[sv/hfc_pkg.sv]
// hfc_pkg: shared types, constants and helpers for the binary16/binary32 converter
// no dependencies; imported by half_float_converter
`timescale 1ns / 1ps
`default_nettype none

package hfc_pkg;

	// direction codes
	localparam logic KIND_H2S = 1'b0;
	localparam logic KIND_S2H = 1'b1;

	// binary32 / binary16 field constants
	localparam logic [7:0]  S_EXP_ALL = 8'hFF;
	localparam logic [4:0]  H_EXP_ALL = 5'h1F;
	localparam logic [9:0]  H_QUIET   = 10'h200;
	localparam logic [7:0]  H2S_BIAS  = 8'd112;
	localparam logic [7:0]  SUB_EXP0  = 8'd113;
	localparam logic [7:0]  S2H_OVF   = 8'd143;
	localparam logic [7:0]  S2H_TINY  = 8'd102;
	localparam logic [7:0]  S2H_SUB   = 8'd112;
	localparam logic [7:0]  SUB_SHIFT = 8'd126;

	// operand class decided in the first stage
	typedef enum logic [2:0] {
		CLS_ZERO,
		CLS_SUB,
		CLS_NORM,
		CLS_INFNAN,
		CLS_OVF
	} cls_t;

	// shift that brings the leading one of a nonzero 10-bit mantissa to bit 10
	function automatic logic [3:0] lead_shift(input logic [9:0] man);
		logic [3:0] lz;
		lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				lz = 4'(10 - i);
			end
		end
		return lz;
	endfunction

endpackage

`default_nettype wire

[sv/half_float_converter.sv]
// half_float_converter: three-stage pipelined IEEE 754 binary16 <-> binary32 converter
// result word comes from the stage-3 register, one word per cycle sustained while out_stall stays low
// reset (arst_n low) clears the stage valid bits only; data registers are not reset
// depends on hfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module half_float_converter
	import hfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic        kind,
	input  wire logic [31:0] operand,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [31:0] result
);

	// stage 1: classify, leading-zero count, subnormal shift amount
	// stage 2: normalize / align, assemble result, decide the rounding increment
	// stage 3: apply the increment (may carry into exponent or up to infinity)
	// each stage advances when the stage after it is empty or moving, so a
	// stalled output still lets bubbles collapse and a word enter upstream

	logic        v_s1, v_s2, v_s3;
	logic        rdy1, rdy2, rdy3;

	assign rdy3     = !v_s3 || !out_stall;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	// ---------------- stage 1 ----------------
	logic        kind_s1;
	logic [31:0] op_s1;
	cls_t        cls_s1;
	logic [3:0]  lz_s1;
	logic [4:0]  sh_s1;

	logic [4:0]  h_exp;
	logic [9:0]  h_man;
	logic [7:0]  s_exp;
	cls_t        cls_d;

	assign h_exp = operand[14:10];
	assign h_man = operand[9:0];
	assign s_exp = operand[30:23];

	always_comb begin
		if (kind == KIND_H2S) begin
			priority if (h_exp == 5'd0 && h_man == 10'd0) begin
				cls_d = CLS_ZERO;
			end else if (h_exp == 5'd0) begin
				cls_d = CLS_SUB;
			end else if (h_exp == H_EXP_ALL) begin
				cls_d = CLS_INFNAN;
			end else begin
				cls_d = CLS_NORM;
			end
		end else begin
			// half exponent = single exponent - 112
			priority if (s_exp == S_EXP_ALL) begin
				cls_d = CLS_INFNAN;
			end else if (s_exp >= S2H_OVF) begin
				cls_d = CLS_OVF;
			end else if (s_exp < S2H_TINY) begin
				cls_d = CLS_ZERO;   // below 2^-25, flush to signed zero
			end else if (s_exp <= S2H_SUB) begin
				cls_d = CLS_SUB;
			end else begin
				cls_d = CLS_NORM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			kind_s1 <= kind;
			op_s1   <= operand;
			cls_s1  <= cls_d;
			lz_s1   <= lead_shift(h_man);
			sh_s1   <= 5'(SUB_SHIFT - s_exp);   // 14..24 for subnormal results
		end
	end

	// ---------------- stage 2 ----------------
	logic [31:0] base_s2;
	logic        inc_s2;

	logic [31:0] base_d;
	logic        inc_d;
	logic        sgn;
	logic [10:0] h_norm;
	logic [23:0] s_man;
	logic [23:0] sub_q;
	logic [23:0] stk_mask;
	logic        sub_rb, sub_st;
	logic [9:0]  pm;
	logic [4:0]  n_exp;

	assign sgn      = (kind_s1 == KIND_H2S) ? op_s1[15] : op_s1[31];
	assign h_norm   = {1'b0, op_s1[9:0]} << lz_s1;
	assign s_man    = {1'b1, op_s1[22:0]};
	assign sub_q    = s_man >> sh_s1;
	assign sub_rb   = s_man[5'(sh_s1 - 5'd1)];
	assign stk_mask = ~(24'hFF_FFFF << (sh_s1 - 5'd1));
	assign sub_st   = |(s_man & stk_mask);
	assign pm       = (op_s1[22:0] != 23'd0) ? (op_s1[22:13] | H_QUIET) : 10'd0;
	assign n_exp    = 5'(op_s1[30:23] - H2S_BIAS);

	always_comb begin
		base_d = 32'd0;
		inc_d  = 1'b0;
		if (kind_s1 == KIND_H2S) begin
			unique case (cls_s1)
				CLS_ZERO:   base_d = {sgn, 31'd0};
				CLS_SUB:    base_d = {sgn, 8'(SUB_EXP0 - 8'(lz_s1)), h_norm[9:0], 13'd0};
				CLS_INFNAN: base_d = {sgn, S_EXP_ALL, op_s1[9:0], 13'd0};
				default:    base_d = {sgn, 8'(8'(op_s1[14:10]) + H2S_BIAS),
				                      op_s1[9:0], 13'd0};
			endcase
		end else begin
			unique case (cls_s1)
				CLS_INFNAN: base_d = {16'd0, sgn, H_EXP_ALL, pm};
				CLS_OVF:    base_d = {16'd0, sgn, H_EXP_ALL, 10'd0};
				CLS_ZERO:   base_d = {16'd0, sgn, 15'd0};
				CLS_SUB: begin
					base_d = {16'd0, sgn, 5'd0, sub_q[9:0]};
					inc_d  = sub_rb && (sub_st || sub_q[0]);
				end
				default: begin
					base_d = {16'd0, sgn, n_exp, op_s1[22:13]};
					inc_d  = op_s1[12] && ((|op_s1[11:0]) || op_s1[13]);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			base_s2 <= base_d;
			inc_s2  <= inc_d;
		end
	end

	// ---------------- stage 3 ----------------
	// increment on the 15-bit magnitude; carry runs into the exponent and
	// can reach infinity, the sign bit is never touched
	logic [31:0] result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			result_s3 <= {base_s2[31:15], base_s2[14:0] + 15'(inc_s2)};
		end
	end

	assign out_valid = v_s3;
	assign result    = result_s3;

endmodule

`default_nettype wire

[sv/hfc_checker.sv]
// hfc_checker: port-level assertions for half_float_converter, bound to the top level
// depends on half_float_converter
`timescale 1ns / 1ps
`default_nettype none

module hfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        kind,
	input wire logic [31:0] operand,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] result
);

	// a stalled input word stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(kind) && $stable(operand))
		else $error("input word changed while stalled");

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("result word changed while stalled");

	// input backs up only when the output side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output word");

	// an accepted word reaches the output if out_stall stays low while it crosses stages 1 and 2
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("word lost in the pipeline");

	// no result word while reset is applied
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result word shown during reset");

endmodule

bind half_float_converter hfc_checker u_hfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.operand   (operand),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result    (result)
);

`default_nettype wire
